>>> rtl/core/tbg_pkg.sv
// -----------------------------------------------------------------------------
// tbg_pkg
// shared constants, types and helpers of the turbo button gate
// -----------------------------------------------------------------------------
package tbg_pkg;

   localparam int NumButtons = 32;
   localparam int BtnIdxW    = $clog2(NumButtons);
   localparam int MaskW      = 32;
   localparam int TimeW      = 32;
   localparam int TickW      = 16;
   localparam int PeriodW    = TickW + 1;
   localparam int ToggleW    = 17;
   localparam int CsrIdxW    = 2;
   localparam int CsrDataW   = 32;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_TURBO_MASK = 2'd0,
      CSR_ON_TICKS   = 2'd1,
      CSR_OFF_TICKS  = 2'd2
   } csr_index_type;

   // one button's stored state
   typedef struct packed {
      logic             held;
      logic [TimeW-1:0] ptime;
   } ring_entry_type;

   // one beat moving down the modulo chain
   typedef struct packed {
      logic               vld;
      logic               last;
      logic               gate;
      logic [BtnIdxW-1:0] idx;
      logic [TimeW-1:0]   dvd;
      logic [PeriodW-1:0] rem;
   } mod_beat_type;

   // zero acts as one; a 16-bit register never exceeds the tick ceiling
   function automatic logic [TickW-1:0] clamp_ticks(input logic [TickW-1:0] v);
      return (v == '0) ? TickW'(1) : v;
   endfunction

endpackage

>>> rtl/core/tbg_if.sv
// -----------------------------------------------------------------------------
// tbg_if
// request and response channels of the turbo button gate
// -----------------------------------------------------------------------------
interface tbg_req_if
   import tbg_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [TimeW-1:0] now;
   logic [MaskW-1:0] pressed;

   modport source (output valid, now, pressed, input ready);
   modport sink   (input valid, now, pressed, output ready);
endinterface

interface tbg_rsp_if
   import tbg_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [MaskW-1:0]   gated;
   logic [ToggleW-1:0] next_toggle;

   modport source (output valid, gated, next_toggle, input ready);
   modport sink   (input valid, gated, next_toggle, output ready);
endinterface

>>> rtl/core/tbg_state_ring.sv
// -----------------------------------------------------------------------------
// tbg_state_ring
// ring of per-button cells holding held flag and press time, rotates one
// place per shift so the head always shows the next button to visit
// -----------------------------------------------------------------------------
module tbg_state_ring
   import tbg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           shift,
   input  ring_entry_type tail_entry,
   output ring_entry_type head
);

   logic [NumButtons-1:0] held_ff;
   logic [TimeW-1:0]      ptime_ff [NumButtons];

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (shift) begin
         held_ff <= {tail_entry.held, held_ff[NumButtons-1:1]};
      end
   end

   // press time only matters while held, so no reset
   always_ff @(posedge clock) begin
      if (shift) begin
         for (int i = 0; i < NumButtons - 1; i++) begin
            ptime_ff[i] <= ptime_ff[i+1];
         end
         ptime_ff[NumButtons-1] <= tail_entry.ptime;
      end
   end

   assign head.held  = held_ff[0];
   assign head.ptime = ptime_ff[0];

endmodule

>>> rtl/core/tbg_mod_cell.sv
// -----------------------------------------------------------------------------
// tbg_mod_cell
// one restoring step of the elapsed-time modulo period reduction
// -----------------------------------------------------------------------------
module tbg_mod_cell
   import tbg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [PeriodW-1:0] period,
   input  mod_beat_type       prev_beat,
   output mod_beat_type       beat
);

   mod_beat_type   beat_ff;
   mod_beat_type   beat_in;
   logic [PeriodW:0] rem_sh;
   logic [PeriodW:0] rem_diff;

   always_comb begin
      rem_sh   = {prev_beat.rem, prev_beat.dvd[TimeW-1]};
      rem_diff = rem_sh - {1'b0, period};
      beat_in  = prev_beat;
      beat_in.dvd = {prev_beat.dvd[TimeW-2:0], 1'b0};
      if (rem_sh >= {1'b0, period}) begin
         beat_in.rem = rem_diff[PeriodW-1:0];
      end else begin
         beat_in.rem = rem_sh[PeriodW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else begin
         beat_ff <= beat_in;
      end
   end

   assign beat = beat_ff;

endmodule

>>> rtl/core/button_turbo_gate.sv
// -----------------------------------------------------------------------------
// button_turbo_gate
// autofire gate: blanks held turbo buttons in the off part of their period
// and reports ticks until the nearest toggle
// -----------------------------------------------------------------------------
//  channel  | dir | handshake        | beat contents
//  ---------+-----+------------------+-------------------------------------
//  req_if   | in  | valid / ready    | now[31:0], pressed[31:0]
//  rsp_if   | out | valid / ready    | gated[31:0], next_toggle[16:0]
//  csr      | in  | csr_we           | csr_index[1:0], csr_wdata[31:0]
//
//  one request passes from accept to the next accept through a sweep of the
//  button ring, the 32-cell modulo chain, the last accumulate and the
//  response register
//  one request is in flight at a time; req_if.ready is high only when idle
//  the response register holds a finished beat while the next request is
//  accepted; a stalled rsp_if holds the block in its done state
//  reset (synchronous) clears all held flags and sets the turbo mask to 0
//  and both tick lengths to 1
// -----------------------------------------------------------------------------
module button_turbo_gate
   import tbg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   tbg_req_if.sink             req_if,
   tbg_rsp_if.source           rsp_if,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SWEEP = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   // configuration registers
   logic [MaskW-1:0] turbo_ff;
   logic [TickW-1:0] on_ff;
   logic [TickW-1:0] off_ff;

   // control
   state_type          state_ff, state_in;
   logic [BtnIdxW-1:0] cnt_ff, cnt_in;

   // per-request payload
   logic [TimeW-1:0]   now_ff;
   logic [MaskW-1:0]   pressed_ff;
   logic [MaskW-1:0]   gated_ff, gated_in;
   logic [ToggleW-1:0] best_ff, best_in;

   // response register
   logic               rsp_vld_ff, rsp_vld_in;
   logic [MaskW-1:0]   rsp_gated_ff;
   logic [ToggleW-1:0] rsp_toggle_ff;

   logic               req_fire;
   logic               rsp_load;
   logic               sweeping;
   logic [PeriodW-1:0] on_c;
   logic [PeriodW-1:0] period_c;

   ring_entry_type     head;
   ring_entry_type     tail_entry;
   logic               turbo_bit;
   logic               press_bit;

   mod_beat_type       chain_in;
   mod_beat_type       chain_beat [TimeW+1];
   mod_beat_type       chain_out;
   logic               past_on;
   logic [PeriodW-1:0] to_edge;

   // ---------------------------------------------------------------------
   // configuration writes, index past the list is dropped
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         turbo_ff <= '0;
         on_ff    <= TickW'(1);
         off_ff   <= TickW'(1);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TURBO_MASK: turbo_ff <= csr_wdata[MaskW-1:0];
            CSR_ON_TICKS:   on_ff    <= csr_wdata[TickW-1:0];
            CSR_OFF_TICKS:  off_ff   <= csr_wdata[TickW-1:0];
            default: ;
         endcase
      end
   end

   assign on_c     = {1'b0, clamp_ticks(on_ff)};
   assign period_c = on_c + {1'b0, clamp_ticks(off_ff)};

   // ---------------------------------------------------------------------
   // handshakes
   // ---------------------------------------------------------------------
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign sweeping     = (state_ff == ST_SWEEP);
   assign rsp_load     = (state_ff == ST_DONE) && (!rsp_vld_ff || rsp_if.ready);

   // ---------------------------------------------------------------------
   // button ring: head is button cnt_ff during the sweep
   // ---------------------------------------------------------------------
   tbg_state_ring u_ring (
      .clock      (clock),
      .reset      (reset),
      .shift      (sweeping),
      .tail_entry (tail_entry),
      .head       (head)
   );

   assign turbo_bit = turbo_ff[cnt_ff];
   assign press_bit = pressed_ff[cnt_ff];

   always_comb begin
      tail_entry = head;
      if (turbo_bit) begin
         // rising edge latches the press time, release forgets the phase
         tail_entry.held = press_bit;
         if (press_bit && !head.held) begin
            tail_entry.ptime = now_ff;
         end
      end
   end

   // ---------------------------------------------------------------------
   // modulo chain: elapsed ticks enter, elapsed mod period leaves
   // ---------------------------------------------------------------------
   always_comb begin
      chain_in.vld  = sweeping && tail_entry.held;
      chain_in.last = sweeping && (cnt_ff == BtnIdxW'(NumButtons - 1));
      chain_in.gate = turbo_bit && press_bit;
      chain_in.idx  = cnt_ff;
      chain_in.dvd  = now_ff - tail_entry.ptime;
      chain_in.rem  = '0;
   end

   assign chain_beat[0] = chain_in;

   for (genvar k = 0; k < TimeW; k++) begin : g_chain
      tbg_mod_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .period    (period_c),
         .prev_beat (chain_beat[k]),
         .beat      (chain_beat[k+1])
      );
   end

   assign chain_out = chain_beat[TimeW];

   // ticks to the next edge of this button's pulse train
   assign past_on = (chain_out.rem >= on_c);
   assign to_edge = past_on ? (period_c - chain_out.rem) : (on_c - chain_out.rem);

   // ---------------------------------------------------------------------
   // accumulate gated mask and nearest toggle
   // ---------------------------------------------------------------------
   always_comb begin
      gated_in = gated_ff;
      best_in  = best_ff;
      if (req_fire) begin
         gated_in = req_if.pressed;
         best_in  = '0;
      end else if (chain_out.vld) begin
         if (chain_out.gate && past_on) begin
            gated_in[chain_out.idx] = 1'b0;
         end
         if ((best_ff == '0) || (ToggleW'(to_edge) < best_ff)) begin
            best_in = ToggleW'(to_edge);
         end
      end
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SWEEP;
               cnt_in   = '0;
            end
         end
         ST_SWEEP: begin
            cnt_in = cnt_ff + BtnIdxW'(1);
            if (cnt_ff == BtnIdxW'(NumButtons - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (chain_out.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (rsp_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      gated_ff <= gated_in;
      best_ff  <= best_in;
      if (req_fire) begin
         now_ff     <= req_if.now;
         pressed_ff <= req_if.pressed;
      end
      if (rsp_load) begin
         rsp_gated_ff  <= gated_ff;
         rsp_toggle_ff <= best_ff;
      end
   end

   assign rsp_if.valid       = rsp_vld_ff;
   assign rsp_if.gated       = rsp_gated_ff;
   assign rsp_if.next_toggle = rsp_toggle_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_last_in_drain: assert property (@(posedge clock) disable iff (reset)
      chain_out.last |-> (state_ff == ST_DRAIN))
      else $error("last beat left the chain outside drain");

   a_idle_chain_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !chain_out.vld)
      else $error("chain beat arrived while idle");

   a_accept_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (sweeping && (cnt_ff == '0)))
      else $error("accepted request did not start the sweep at button zero");

   a_done_from_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_DONE) |-> $past(chain_out.last))
      else $error("done reached without the last chain beat");

endmodule
